FILE: rtl/core/polygon_rect_clip_macros.svh
// Assertion helpers used by the clipper back part (prc_back).
`ifndef POLYGON_RECT_CLIP_MACROS_SVH
`define POLYGON_RECT_CLIP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define PRC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/prc_pkg.sv
`default_nettype none

package prc_pkg;

   // Coordinate width and the widths that follow from it.
   localparam int CoordBits = 16;
   localparam int ExtBits   = CoordBits + 1;
   localparam int ProdBits  = 2 * ExtBits;
   localparam int CntBits   = $clog2(ExtBits);

   // Clip stages, per-stage list limit and per-item result limit.
   localparam int Stages    = 4;
   localparam int StageBits = $clog2(Stages);
   localparam int CloseBits = $clog2(Stages + 1);
   localparam int ListCap   = 16;
   localparam int CapBits   = $clog2(ListCap + 1);
   localparam int ResultCap = 12;
   localparam int RcntBits  = $clog2(ResultCap + 1);

   // Input queue between the front and back parts.
   localparam int QueueDepth = 2;
   localparam int QPtrBits   = $clog2(QueueDepth);
   localparam int QCntBits   = $clog2(QueueDepth + 1);

   localparam int CsrIdxBits = 2;
   localparam int ColorBits  = 24;

   typedef logic signed [CoordBits-1:0] coord_type;
   typedef logic signed [ExtBits-1:0]   ext_type;

   localparam coord_type ClipLowReset  = coord_type'(0);
   localparam coord_type ClipHighReset = coord_type'(32767);

   typedef enum logic [CsrIdxBits-1:0] {
      CsrLeft   = 2'd0,
      CsrRight  = 2'd1,
      CsrBottom = 2'd2,
      CsrTop    = 2'd3
   } csr_index_type;

   typedef enum logic [StageBits-1:0] {
      StageLeft   = 2'd0,
      StageRight  = 2'd1,
      StageBottom = 2'd2,
      StageTop    = 2'd3
   } stage_type;

   // One queued vertex with the color of its polygon.
   typedef struct packed {
      coord_type              x;
      coord_type              y;
      logic [ColorBits-1:0]   color;
      logic                   fin;
   } item_type;

   // Intersection request: b0 + trunc(n1 * n2 / d).
   typedef struct packed {
      logic      start;
      ext_type   n1;
      ext_type   n2;
      ext_type   d;
      coord_type b0;
   } div_req_type;

   typedef struct packed {
      logic      done;
      coord_type res;
   } div_rsp_type;

   typedef enum logic [1:0] {
      DivIdle = 2'd0,
      DivMul  = 2'd1,
      DivRun  = 2'd2,
      DivDone = 2'd3
   } div_state_type;

   typedef enum logic [1:0] {
      BackIdle  = 2'd0,
      BackSched = 2'd1,
      BackWait  = 2'd2
   } back_state_type;

endpackage

`default_nettype wire

FILE: rtl/core/prc_if.sv
`default_nettype none

// Vertex input channel.
interface prc_req_if;
   logic                valid;
   logic                ready;
   prc_pkg::coord_type  px;
   prc_pkg::coord_type  py;
   logic [7:0]          red;
   logic [7:0]          green;
   logic [7:0]          blue;
   logic                final_vertex;

   modport source (output valid, px, py, red, green, blue, final_vertex, input ready);
   modport sink   (input valid, px, py, red, green, blue, final_vertex, output ready);
endinterface

// Clipped vertex output channel.
interface prc_rsp_if;
   logic                valid;
   logic                ready;
   prc_pkg::coord_type  qx;
   prc_pkg::coord_type  qy;
   logic [7:0]          out_red;
   logic [7:0]          out_green;
   logic [7:0]          out_blue;
   logic                end_of_polygon;
   logic                clipped_away;

   modport source (output valid, qx, qy, out_red, out_green, out_blue, end_of_polygon,
                   clipped_away, input ready);
   modport sink   (input valid, qx, qy, out_red, out_green, out_blue, end_of_polygon,
                   clipped_away, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/prc_front.sv
`default_nettype none

module prc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   prc_req_if.sink                req_ch,
   output prc_pkg::item_type      q_item_o,
   output logic                   q_valid_o,
   input  wire logic              q_pop_i
);

   logic                               open_ff, open_in;
   logic [prc_pkg::ColorBits-1:0]      color_ff, color_in;
   prc_pkg::item_type                  slot_ff [prc_pkg::QueueDepth];
   prc_pkg::item_type                  slot_in [prc_pkg::QueueDepth];
   logic [prc_pkg::QPtrBits-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [prc_pkg::QCntBits-1:0]       cnt_ff, cnt_in;
   logic                               accept;
   prc_pkg::item_type                  entry;

   assign req_ch.ready = (cnt_ff != prc_pkg::QCntBits'(prc_pkg::QueueDepth));
   assign accept       = req_ch.valid && req_ch.ready;
   assign q_valid_o    = (cnt_ff != '0);
   assign q_item_o     = slot_ff[rd_ff];

   // Classify the vertex: the first one of a polygon latches its color.
   always_comb begin
      open_in  = open_ff;
      color_in = color_ff;
      slot_in  = slot_ff;
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      entry.x     = req_ch.px;
      entry.y     = req_ch.py;
      entry.fin   = req_ch.final_vertex;
      entry.color = open_ff ? color_ff : {req_ch.red, req_ch.green, req_ch.blue};
      if (accept) begin
         slot_in[wr_ff] = entry;
         wr_in          = wr_ff + prc_pkg::QPtrBits'(1);
         color_in       = entry.color;
         open_in        = !req_ch.final_vertex;
      end
      if (q_pop_i) begin
         rd_in = rd_ff + prc_pkg::QPtrBits'(1);
      end
      cnt_in = cnt_ff + prc_pkg::QCntBits'(accept) - prc_pkg::QCntBits'(q_pop_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         color_ff <= '0;
         wr_ff    <= '0;
         rd_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         open_ff  <= open_in;
         color_ff <= color_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/prc_div.sv
`default_nettype none

module prc_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire prc_pkg::div_req_type req_i,
   output prc_pkg::div_rsp_type      rsp_o
);

   prc_pkg::div_state_type             state_ff, state_in;
   logic [prc_pkg::ExtBits-1:0]        mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   logic [prc_pkg::ExtBits-1:0]        den_ff, den_in;
   logic [prc_pkg::ExtBits-1:0]        rem_ff, rem_in, quo_ff, quo_in;
   logic [prc_pkg::CntBits-1:0]        cnt_ff, cnt_in;
   logic                               neg_ff, neg_in;
   prc_pkg::coord_type                 b0_ff, b0_in;
   logic [prc_pkg::ProdBits-1:0]       prod;
   logic [prc_pkg::ExtBits:0]          trial, diff;
   logic                               take;
   logic signed [prc_pkg::ExtBits:0]   sum;

   function automatic logic [prc_pkg::ExtBits-1:0] mag(input prc_pkg::ext_type v);
      logic [prc_pkg::ExtBits-1:0] u;
      u = v;
      return v[prc_pkg::ExtBits-1] ? (~u + prc_pkg::ExtBits'(1)) : u;
   endfunction

   assign prod  = prc_pkg::ProdBits'(mag_a_ff) * prc_pkg::ProdBits'(mag_b_ff);
   assign trial = {rem_ff, quo_ff[prc_pkg::ExtBits-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign take  = (trial >= {1'b0, den_ff});
   assign sum   = neg_ff ? ({b0_ff[prc_pkg::CoordBits-1], b0_ff[prc_pkg::CoordBits-1], b0_ff}
                            - $signed({1'b0, quo_ff}))
                         : ({b0_ff[prc_pkg::CoordBits-1], b0_ff[prc_pkg::CoordBits-1], b0_ff}
                            + $signed({1'b0, quo_ff}));

   assign rsp_o.done = (state_ff == prc_pkg::DivDone);
   assign rsp_o.res  = sum[prc_pkg::CoordBits-1:0];

   // Magnitudes, one multiply, then restoring division one quotient bit a cycle.
   always_comb begin
      state_in = state_ff;
      mag_a_in = mag_a_ff;
      mag_b_in = mag_b_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      b0_in    = b0_ff;
      case (state_ff)
         prc_pkg::DivIdle: begin
            if (req_i.start) begin
               mag_a_in = mag(req_i.n1);
               mag_b_in = mag(req_i.n2);
               den_in   = mag(req_i.d);
               neg_in   = req_i.n1[prc_pkg::ExtBits-1] ^ req_i.n2[prc_pkg::ExtBits-1]
                          ^ req_i.d[prc_pkg::ExtBits-1];
               b0_in    = req_i.b0;
               state_in = prc_pkg::DivMul;
            end
         end
         prc_pkg::DivMul: begin
            // The quotient is bounded by |n2|, so the upper half is already below d.
            rem_in   = prod[prc_pkg::ProdBits-1:prc_pkg::ExtBits];
            quo_in   = prod[prc_pkg::ExtBits-1:0];
            cnt_in   = '0;
            state_in = prc_pkg::DivRun;
         end
         prc_pkg::DivRun: begin
            rem_in = take ? diff[prc_pkg::ExtBits-1:0] : trial[prc_pkg::ExtBits-1:0];
            quo_in = {quo_ff[prc_pkg::ExtBits-2:0], take};
            cnt_in = cnt_ff + prc_pkg::CntBits'(1);
            if (cnt_ff == prc_pkg::CntBits'(prc_pkg::ExtBits - 1)) begin
               state_in = prc_pkg::DivDone;
            end
         end
         prc_pkg::DivDone: begin
            state_in = prc_pkg::DivIdle;
         end
         default: begin
            state_in = prc_pkg::DivIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prc_pkg::DivIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      b0_ff    <= b0_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/prc_back.sv
`default_nettype none

`include "polygon_rect_clip_macros.svh"

module prc_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire prc_pkg::item_type            q_item_i,
   input  wire logic                         q_valid_i,
   output logic                              q_pop_o,
   output prc_pkg::div_req_type              div_req_o,
   input  wire prc_pkg::div_rsp_type         div_rsp_i,
   input  wire logic                         csr_we,
   input  wire logic [prc_pkg::CsrIdxBits-1:0] csr_index,
   input  wire logic [prc_pkg::CoordBits-1:0]  csr_wdata,
   prc_rsp_if.source                         rsp_ch
);

   localparam int S = prc_pkg::Stages;

   prc_pkg::back_state_type          state_ff, state_in;
   prc_pkg::coord_type               clip_l_ff, clip_l_in, clip_r_ff, clip_r_in;
   prc_pkg::coord_type               clip_b_ff, clip_b_in, clip_t_ff, clip_t_in;

   // Per-stage first and previous vertex.
   prc_pkg::coord_type               first_x_ff [S], first_x_in [S];
   prc_pkg::coord_type               first_y_ff [S], first_y_in [S];
   prc_pkg::coord_type               prev_x_ff  [S], prev_x_in  [S];
   prc_pkg::coord_type               prev_y_ff  [S], prev_y_in  [S];
   logic [S-1:0]                     has_first_ff, has_first_in;

   // Two-slot output buffer of each stage, filled only while it is empty.
   prc_pkg::coord_type               bx_ff [S][2], bx_in [S][2];
   prc_pkg::coord_type               by_ff [S][2], by_in [S][2];
   logic [1:0]                       fcnt_ff [S], fcnt_in [S];
   logic [1:0]                       rd_ff   [S], rd_in   [S];
   logic [prc_pkg::CapBits-1:0]      pcnt_ff [S], pcnt_in [S];

   // Current item.
   prc_pkg::coord_type               pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic [prc_pkg::ColorBits-1:0]    color_ff, color_in;
   logic                             fin_ff, fin_in, have_pt_ff, have_pt_in;
   logic [prc_pkg::CloseBits-1:0]    close_ff, close_in;

   // Held-back clipped vertex.
   prc_pkg::coord_type               pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic                             any_ff, any_in;
   logic [prc_pkg::RcntBits-1:0]     rcnt_ff, rcnt_in;

   // Edge waiting for its intersection.
   prc_pkg::stage_type               op_stage_ff, op_stage_in;
   prc_pkg::coord_type               op_bound_ff, op_bound_in;

   // Output register.
   logic                             out_valid_ff;
   prc_pkg::coord_type               qx_ff, qy_ff;
   logic                             eop_ff, gone_ff;
   logic [prc_pkg::ColorBits-1:0]    ocolor_ff;
   logic                             out_free, out_load, out_eop, out_gone, need_out;
   prc_pkg::coord_type               out_x, out_y;

   // Edge operation signals.
   logic                             op_go, op_close, found, in1, in2;
   prc_pkg::stage_type               op_stage, sidx;
   prc_pkg::coord_type               op_px, op_py, x1, y1, x2, y2;
   prc_pkg::coord_type               bound, a0, a1, b0v, b1v, isec_x, isec_y;
   logic                             bufs_empty, bufs_sane;

   assign out_free             = !out_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.qx            = qx_ff;
   assign rsp_ch.qy            = qy_ff;
   assign rsp_ch.out_red       = ocolor_ff[23:16];
   assign rsp_ch.out_green     = ocolor_ff[15:8];
   assign rsp_ch.out_blue      = ocolor_ff[7:0];
   assign rsp_ch.end_of_polygon = eop_ff;
   assign rsp_ch.clipped_away  = gone_ff;

   // Configuration writes.
   always_comb begin
      clip_l_in = clip_l_ff;
      clip_r_in = clip_r_ff;
      clip_b_in = clip_b_ff;
      clip_t_in = clip_t_ff;
      if (csr_we) begin
         case (prc_pkg::csr_index_type'(csr_index))
            prc_pkg::CsrLeft:   clip_l_in = csr_wdata;
            prc_pkg::CsrRight:  clip_r_in = csr_wdata;
            prc_pkg::CsrBottom: clip_b_in = csr_wdata;
            prc_pkg::CsrTop:    clip_t_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Buffer status for the checks below.
   always_comb begin
      bufs_empty = 1'b1;
      bufs_sane  = 1'b1;
      for (int s = 0; s < S; s++) begin
         if (rd_ff[s] != fcnt_ff[s]) bufs_empty = 1'b0;
         if (rd_ff[s] > fcnt_ff[s] || fcnt_ff[s] > 2'd2) bufs_sane = 1'b0;
      end
   end

   // Scheduler: drain the deepest buffer first, then the new vertex, then closing edges, then the polygon end.
   always_comb begin
      state_in     = state_ff;
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      has_first_in = has_first_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      fcnt_in      = fcnt_ff;
      rd_in        = rd_ff;
      pcnt_in      = pcnt_ff;
      pt_x_in      = pt_x_ff;
      pt_y_in      = pt_y_ff;
      color_in     = color_ff;
      fin_in       = fin_ff;
      have_pt_in   = have_pt_ff;
      close_in     = close_ff;
      pend_x_in    = pend_x_ff;
      pend_y_in    = pend_y_ff;
      any_in       = any_ff;
      rcnt_in      = rcnt_ff;
      op_stage_in  = op_stage_ff;
      op_bound_in  = op_bound_ff;
      q_pop_o      = 1'b0;
      div_req_o    = '0;
      out_load     = 1'b0;
      out_x        = '0;
      out_y        = '0;
      out_eop      = 1'b0;
      out_gone     = 1'b0;
      need_out     = 1'b0;
      op_go        = 1'b0;
      op_close     = 1'b0;
      op_stage     = prc_pkg::StageLeft;
      op_px        = pt_x_ff;
      op_py        = pt_y_ff;
      found        = 1'b0;
      sidx         = op_stage_ff;
      x1 = '0; y1 = '0; x2 = '0; y2 = '0;
      in1 = 1'b0; in2 = 1'b0;
      bound = '0; a0 = '0; a1 = '0; b0v = '0; b1v = '0;
      isec_x = '0; isec_y = '0;

      case (state_ff)
         prc_pkg::BackIdle: begin
            if (q_valid_i) begin
               q_pop_o    = 1'b1;
               pt_x_in    = q_item_i.x;
               pt_y_in    = q_item_i.y;
               color_in   = q_item_i.color;
               fin_in     = q_item_i.fin;
               have_pt_in = 1'b1;
               close_in   = '0;
               rcnt_in    = '0;
               for (int s = 0; s < S; s++) pcnt_in[s] = '0;
               state_in   = prc_pkg::BackSched;
            end
         end
         prc_pkg::BackSched: begin
            if (rd_ff[S-1] != fcnt_ff[S-1]) begin
               // Last stage output: release the held vertex and hold this one.
               need_out = any_ff && (rcnt_ff < prc_pkg::RcntBits'(prc_pkg::ResultCap));
               if (!need_out || out_free) begin
                  if (need_out) begin
                     out_load = 1'b1;
                     out_x    = pend_x_ff;
                     out_y    = pend_y_ff;
                     rcnt_in  = rcnt_ff + prc_pkg::RcntBits'(1);
                  end
                  pend_x_in     = bx_ff[S-1][rd_ff[S-1][0]];
                  pend_y_in     = by_ff[S-1][rd_ff[S-1][0]];
                  any_in        = 1'b1;
                  rd_in[S-1]    = rd_ff[S-1] + 2'd1;
               end
            end else begin
               for (int s = S - 2; s >= 0; s--) begin
                  if (!found && rd_ff[s] != fcnt_ff[s]) begin
                     found    = 1'b1;
                     op_go    = 1'b1;
                     op_stage = prc_pkg::stage_type'(s + 1);
                     op_px    = bx_ff[s][rd_ff[s][0]];
                     op_py    = by_ff[s][rd_ff[s][0]];
                     rd_in[s] = rd_ff[s] + 2'd1;
                  end
               end
               if (!found) begin
                  if (have_pt_ff) begin
                     op_go      = 1'b1;
                     op_stage   = prc_pkg::StageLeft;
                     have_pt_in = 1'b0;
                  end else if (fin_ff && close_ff < prc_pkg::CloseBits'(S)) begin
                     op_stage = prc_pkg::stage_type'(close_ff[prc_pkg::StageBits-1:0]);
                     op_go    = has_first_ff[op_stage];
                     op_close = 1'b1;
                     close_in = close_ff + prc_pkg::CloseBits'(1);
                  end else if (fin_ff) begin
                     // Polygon end: the held vertex closes it, or it was clipped away.
                     need_out = (rcnt_ff < prc_pkg::RcntBits'(prc_pkg::ResultCap));
                     if (!need_out || out_free) begin
                        out_load  = need_out;
                        out_x     = any_ff ? pend_x_ff : '0;
                        out_y     = any_ff ? pend_y_ff : '0;
                        out_eop   = 1'b1;
                        out_gone  = !any_ff;
                        any_in    = 1'b0;
                        pend_x_in = '0;
                        pend_y_in = '0;
                        state_in  = prc_pkg::BackIdle;
                     end
                  end else begin
                     state_in = prc_pkg::BackIdle;
                  end
               end
            end
         end
         prc_pkg::BackWait: begin
            // The intersection follows the start vertex in the stage buffer.
            if (div_rsp_i.done) begin
               if (op_stage_ff == prc_pkg::StageLeft || op_stage_ff == prc_pkg::StageRight) begin
                  isec_x = op_bound_ff;
                  isec_y = div_rsp_i.res;
               end else begin
                  isec_x = div_rsp_i.res;
                  isec_y = op_bound_ff;
               end
               if (pcnt_ff[sidx] < prc_pkg::CapBits'(prc_pkg::ListCap)) begin
                  bx_in[sidx][fcnt_ff[sidx][0]] = isec_x;
                  by_in[sidx][fcnt_ff[sidx][0]] = isec_y;
                  fcnt_in[sidx] = fcnt_ff[sidx] + 2'd1;
                  pcnt_in[sidx] = pcnt_ff[sidx] + prc_pkg::CapBits'(1);
               end
               state_in = prc_pkg::BackSched;
            end
         end
         default: begin
            state_in = prc_pkg::BackIdle;
         end
      endcase

      // One edge of one stage.
      if (op_go) begin
         sidx = op_stage;
         if (!op_close && !has_first_ff[sidx]) begin
            first_x_in[sidx]   = op_px;
            first_y_in[sidx]   = op_py;
            prev_x_in[sidx]    = op_px;
            prev_y_in[sidx]    = op_py;
            has_first_in[sidx] = 1'b1;
         end else begin
            x1 = prev_x_ff[sidx];
            y1 = prev_y_ff[sidx];
            x2 = op_close ? first_x_ff[sidx] : op_px;
            y2 = op_close ? first_y_ff[sidx] : op_py;
            if (op_close) begin
               has_first_in[sidx] = 1'b0;
            end else begin
               prev_x_in[sidx] = op_px;
               prev_y_in[sidx] = op_py;
            end
            case (sidx)
               prc_pkg::StageLeft: begin
                  in1 = (x1 >= clip_l_ff); in2 = (x2 >= clip_l_ff); bound = clip_l_ff;
                  a0 = x1; a1 = x2; b0v = y1; b1v = y2;
               end
               prc_pkg::StageRight: begin
                  in1 = (x1 <= clip_r_ff); in2 = (x2 <= clip_r_ff); bound = clip_r_ff;
                  a0 = x1; a1 = x2; b0v = y1; b1v = y2;
               end
               prc_pkg::StageBottom: begin
                  in1 = (y1 >= clip_b_ff); in2 = (y2 >= clip_b_ff); bound = clip_b_ff;
                  a0 = y1; a1 = y2; b0v = x1; b1v = x2;
               end
               default: begin
                  in1 = (y1 <= clip_t_ff); in2 = (y2 <= clip_t_ff); bound = clip_t_ff;
                  a0 = y1; a1 = y2; b0v = x1; b1v = x2;
               end
            endcase
            fcnt_in[sidx] = '0;
            rd_in[sidx]   = '0;
            if (in1 && pcnt_ff[sidx] < prc_pkg::CapBits'(prc_pkg::ListCap)) begin
               bx_in[sidx][0] = x1;
               by_in[sidx][0] = y1;
               fcnt_in[sidx]  = 2'd1;
               pcnt_in[sidx]  = pcnt_ff[sidx] + prc_pkg::CapBits'(1);
            end
            if (in1 != in2) begin
               div_req_o.start = 1'b1;
               div_req_o.n1    = prc_pkg::ext_type'(bound) - prc_pkg::ext_type'(a0);
               div_req_o.n2    = prc_pkg::ext_type'(b1v) - prc_pkg::ext_type'(b0v);
               div_req_o.d     = prc_pkg::ext_type'(a1) - prc_pkg::ext_type'(a0);
               div_req_o.b0    = b0v;
               op_stage_in     = sidx;
               op_bound_in     = bound;
               state_in        = prc_pkg::BackWait;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prc_pkg::BackIdle;
         clip_l_ff    <= prc_pkg::ClipLowReset;
         clip_r_ff    <= prc_pkg::ClipHighReset;
         clip_b_ff    <= prc_pkg::ClipLowReset;
         clip_t_ff    <= prc_pkg::ClipHighReset;
         has_first_ff <= '0;
         for (int s = 0; s < S; s++) begin
            fcnt_ff[s] <= '0;
            rd_ff[s]   <= '0;
         end
         have_pt_ff   <= 1'b0;
         fin_ff       <= 1'b0;
         any_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clip_l_ff    <= clip_l_in;
         clip_r_ff    <= clip_r_in;
         clip_b_ff    <= clip_b_in;
         clip_t_ff    <= clip_t_in;
         has_first_ff <= has_first_in;
         fcnt_ff      <= fcnt_in;
         rd_ff        <= rd_in;
         have_pt_ff   <= have_pt_in;
         fin_ff       <= fin_in;
         any_ff       <= any_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      first_x_ff  <= first_x_in;
      first_y_ff  <= first_y_in;
      prev_x_ff   <= prev_x_in;
      prev_y_ff   <= prev_y_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      pcnt_ff     <= pcnt_in;
      pt_x_ff     <= pt_x_in;
      pt_y_ff     <= pt_y_in;
      color_ff    <= color_in;
      close_ff    <= close_in;
      pend_x_ff   <= pend_x_in;
      pend_y_ff   <= pend_y_in;
      rcnt_ff     <= rcnt_in;
      op_stage_ff <= op_stage_in;
      op_bound_ff <= op_bound_in;
      if (out_load) begin
         qx_ff     <= out_x;
         qy_ff     <= out_y;
         eop_ff    <= out_eop;
         gone_ff   <= out_gone;
         ocolor_ff <= color_ff;
      end
   end

   // Checks.
   `PRC_ASSERT_SAME(a_idle_drained, clock, reset, state_ff == prc_pkg::BackIdle,
                    bufs_empty && !have_pt_ff, "idle with vertex work left over")
   `PRC_ASSERT_SAME(a_bufs_sane, clock, reset, 1'b1, bufs_sane,
                    "stage buffer read past fill or overfilled")
   `PRC_ASSERT_SAME(a_div_in_wait, clock, reset, div_rsp_i.done,
                    state_ff == prc_pkg::BackWait, "intersection done while not waiting")
   `PRC_ASSERT_NEXT(a_end_clears, clock, reset,
                    state_ff == prc_pkg::BackSched && state_in == prc_pkg::BackIdle && fin_ff,
                    !any_ff, "held vertex survives the polygon end")

endmodule

`default_nettype wire

FILE: rtl/core/polygon_rect_clip.sv
// Streaming rectangle clipper for polygons. Vertices enter on req_ch, one item each,
// the last vertex of a polygon flagged by final_vertex; clipped vertices leave on rsp_ch
// in order, the last one flagged end_of_polygon, and a polygon that lies wholly outside
// gives a single item with clipped_away set. The rectangle is written through csr_*
// (0 left, 1 right, 2 bottom, 3 top, inclusive); the user must do so only while no polygon
// is in flight, as the block does not enforce it. A two-entry queue takes vertices while
// earlier ones are still clipped. Every edge that crosses a boundary goes through the shared
// intersection unit (one multiply, then one quotient bit per cycle over 17 bits), and the
// final vertex adds the four closing edges.

`default_nettype none

module polygon_rect_clip (
   input  wire logic                           clock,
   input  wire logic                           reset,
   prc_req_if.sink                             req_ch,
   prc_rsp_if.source                           rsp_ch,
   input  wire logic                           csr_we,
   input  wire logic [prc_pkg::CsrIdxBits-1:0] csr_index,
   input  wire logic [prc_pkg::CoordBits-1:0]  csr_wdata
);

   prc_pkg::item_type      q_item;
   logic                   q_valid;
   logic                   q_pop;
   prc_pkg::div_req_type   div_req;
   prc_pkg::div_rsp_type   div_rsp;

   prc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .q_item_o  (q_item),
      .q_valid_o (q_valid),
      .q_pop_i   (q_pop)
   );

   prc_div u_div (
      .clock (clock),
      .reset (reset),
      .req_i (div_req),
      .rsp_o (div_rsp)
   );

   prc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_item_i  (q_item),
      .q_valid_i (q_valid),
      .q_pop_o   (q_pop),
      .div_req_o (div_req),
      .div_rsp_i (div_rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

FILE: tb/tb_polygon_rect_clip.sv
`timescale 1ns / 1ps

module tb_polygon_rect_clip;

   // Expected clipped vertex.
   typedef struct packed {
      prc_pkg::coord_type x;
      prc_pkg::coord_type y;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic       eop;
      logic       gone;
   } vertex_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [prc_pkg::CsrIdxBits-1:0] csr_index;
   logic [prc_pkg::CoordBits-1:0]  csr_wdata;

   prc_req_if req_ch ();
   prc_rsp_if rsp_ch ();

   polygon_rect_clip uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clipper state mirrored in the predictor.
   int         bound_left, bound_right, bound_bottom, bound_top;
   longint     first_x [4], first_y [4], last_x [4], last_y [4];
   bit         have_first [4];
   logic [23:0] poly_color;
   bit         vertex_held;
   longint     held_x, held_y;

   vertex_type clipped_q [$];
   int         send_idle_pct;
   int         recv_idle_pct;
   int         error_count;
   int         item_count;
   int         result_count;
   longint     cycle_count;

   localparam longint CycleLimit = 3000000;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("[polygon_rect_clip] ERROR");
         $finish;
      end
   end

   function automatic bit is_inside(int s, longint x, longint y);
      case (s)
         prc_pkg::StageLeft:   return x >= bound_left;
         prc_pkg::StageRight:  return x <= bound_right;
         prc_pkg::StageBottom: return y >= bound_bottom;
         default:              return y <= bound_top;
      endcase
   endfunction

   // Boundary crossing: b0 + (bound - a0) * (b1 - b0) / (a1 - a0), truncated toward zero.
   function automatic longint cross_at(longint a0, longint a1, longint b0, longint b1,
                                       longint bnd);
      if (a1 == a0) return b0;
      return b0 + ((bnd - a0) * (b1 - b0)) / (a1 - a0);
   endfunction

   function automatic void clip_one_edge(int s, longint x1, longint y1, longint x2,
                                         longint y2, ref longint ox [$], ref longint oy [$]);
      bit in1;
      bit in2;
      in1 = is_inside(s, x1, y1);
      in2 = is_inside(s, x2, y2);
      if (in1) begin
         ox.push_back(x1);
         oy.push_back(y1);
      end
      if (in1 != in2) begin
         case (s)
            prc_pkg::StageLeft: begin
               ox.push_back(bound_left);
               oy.push_back(cross_at(x1, x2, y1, y2, bound_left));
            end
            prc_pkg::StageRight: begin
               ox.push_back(bound_right);
               oy.push_back(cross_at(x1, x2, y1, y2, bound_right));
            end
            prc_pkg::StageBottom: begin
               ox.push_back(cross_at(y1, y2, x1, x2, bound_bottom));
               oy.push_back(bound_bottom);
            end
            default: begin
               ox.push_back(cross_at(y1, y2, x1, x2, bound_top));
               oy.push_back(bound_top);
            end
         endcase
      end
   endfunction

   function automatic void expect_vertex(longint x, longint y, bit eop, bit gone);
      vertex_type v;
      v.x    = prc_pkg::coord_type'(x);
      v.y    = prc_pkg::coord_type'(y);
      v.r    = poly_color[23:16];
      v.g    = poly_color[15:8];
      v.b    = poly_color[7:0];
      v.eop  = eop;
      v.gone = gone;
      clipped_q.push_back(v);
   endfunction

   // Pushes one vertex through the four clip stages and queues what comes out.
   function automatic void predict_clip(prc_pkg::coord_type px, prc_pkg::coord_type py,
                                        logic [23:0] color, bit fin);
      longint cx [$];
      longint cy [$];
      longint nx [$];
      longint ny [$];
      if (!have_first[0]) poly_color = color;
      cx.push_back(longint'(px));
      cy.push_back(longint'(py));
      for (int s = 0; s < 4; s++) begin
         nx.delete();
         ny.delete();
         foreach (cx[i]) begin
            if (!have_first[s]) begin
               first_x[s]    = cx[i];
               first_y[s]    = cy[i];
               have_first[s] = 1'b1;
            end else begin
               clip_one_edge(s, last_x[s], last_y[s], cx[i], cy[i], nx, ny);
            end
            last_x[s] = cx[i];
            last_y[s] = cy[i];
         end
         if (fin && have_first[s]) begin
            clip_one_edge(s, last_x[s], last_y[s], first_x[s], first_y[s], nx, ny);
            have_first[s] = 1'b0;
         end
         cx = nx;
         cy = ny;
      end
      foreach (cx[i]) begin
         if (vertex_held) expect_vertex(held_x, held_y, 1'b0, 1'b0);
         held_x      = cx[i];
         held_y      = cy[i];
         vertex_held = 1'b1;
      end
      if (fin) begin
         if (vertex_held) expect_vertex(held_x, held_y, 1'b1, 1'b0);
         else expect_vertex(0, 0, 1'b1, 1'b1);
         vertex_held = 1'b0;
      end
   endfunction

   // Result side: random stalls, each accepted item checked against the oldest expectation.
   always @(posedge clock) begin
      vertex_type got;
      vertex_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.qx, rsp_ch.qy, rsp_ch.out_red, rsp_ch.out_green,
                   rsp_ch.out_blue, rsp_ch.end_of_polygon, rsp_ch.clipped_away};
            result_count <= result_count + 1;
            if (clipped_q.size() == 0) begin
               $display("%0t: unexpected item %h", $time, got);
               error_count <= error_count + 1;
            end else begin
               want = clipped_q.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected x=%0d y=%0d rgb=%h%h%h eop=%b gone=%b",
                           $time, want.x, want.y, want.r, want.g, want.b, want.eop,
                           want.gone);
                  $display("%0t:            actual x=%0d y=%0d rgb=%h%h%h eop=%b gone=%b",
                           $time, got.x, got.y, got.r, got.g, got.b, got.eop, got.gone);
                  error_count <= error_count + 1;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Valid stays high after an accepted item; it drops only for an idle gap or in wait_idle.
   task automatic send_vertex(prc_pkg::coord_type px, prc_pkg::coord_type py,
                              logic [23:0] color, bit fin);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.px           <= px;
      req_ch.py           <= py;
      req_ch.red          <= color[23:16];
      req_ch.green        <= color[15:8];
      req_ch.blue         <= color[7:0];
      req_ch.final_vertex <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_clip(px, py, color, fin);
      item_count++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (clipped_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_bound(prc_pkg::csr_index_type idx, prc_pkg::coord_type value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         prc_pkg::CsrLeft:   bound_left   = value;
         prc_pkg::CsrRight:  bound_right  = value;
         prc_pkg::CsrBottom: bound_bottom = value;
         default:            bound_top    = value;
      endcase
   endtask

   task automatic set_rect(prc_pkg::coord_type l, prc_pkg::coord_type r,
                           prc_pkg::coord_type b, prc_pkg::coord_type t);
      wait_idle();
      write_bound(prc_pkg::CsrLeft, l);
      write_bound(prc_pkg::CsrRight, r);
      write_bound(prc_pkg::CsrBottom, b);
      write_bound(prc_pkg::CsrTop, t);
      csr_we <= 1'b0;
   endtask

   function automatic prc_pkg::coord_type rand_coord();
      case ($urandom_range(3))
         0:       return prc_pkg::coord_type'($urandom);
         1:       return prc_pkg::coord_type'($urandom_range(32767));
         default: return prc_pkg::coord_type'(int'($urandom_range(400)) - 200);
      endcase
   endfunction

   task automatic send_polygon(int n);
      logic [23:0] color;
      color = 24'($urandom);
      for (int i = 0; i < n; i++) send_vertex(rand_coord(), rand_coord(), color, i == n - 1);
   endtask

   // Directed: extremes, inside, crossing, single vertex and wholly outside polygons.
   task automatic test_directed();
      send_vertex(16'sd10, 16'sd10, 24'hFFFFFF, 1'b0);
      send_vertex(16'sd100, 16'sd10, 24'h000000, 1'b0);
      send_vertex(16'sd50, 16'sd90, 24'h000000, 1'b1);
      send_vertex(-16'sd32768, -16'sd32768, 24'h123456, 1'b0);
      send_vertex(16'sd32767, -16'sd32768, 24'h0, 1'b0);
      send_vertex(16'sd32767, 16'sd32767, 24'h0, 1'b0);
      send_vertex(-16'sd32768, 16'sd32767, 24'h0, 1'b1);
      send_vertex(16'sd5, 16'sd5, 24'hA5A5A5, 1'b1);
      send_vertex(-16'sd5, 16'sd5, 24'h5A5A5A, 1'b1);
      send_vertex(-16'sd50, -16'sd50, 24'h00FF00, 1'b0);
      send_vertex(-16'sd10, -16'sd60, 24'h0, 1'b1);
      send_vertex(-16'sd20, 16'sd30, 24'h0000FF, 1'b0);
      send_vertex(16'sd40, 16'sd30, 24'h0, 1'b1);
      // Inverted rectangle drops everything.
      set_rect(16'sd100, -16'sd100, 16'sd50, -16'sd50);
      send_vertex(16'sd0, 16'sd0, 24'hC3C3C3, 1'b0);
      send_vertex(16'sd10, 16'sd0, 24'h0, 1'b1);
      set_rect(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
      send_polygon(3);
   endtask

   task automatic test_random(int items);
      int sent;
      sent = 0;
      while (sent < items) begin
         int n;
         n = ($urandom_range(9) == 0) ? 1 : int'($urandom_range(6, 3));
         send_polygon(n);
         sent += n;
      end
   endtask

   task automatic test_rectangles();
      set_rect(-16'sd100, 16'sd100, -16'sd100, 16'sd100);
      test_random(100);
      set_rect(prc_pkg::coord_type'($urandom), prc_pkg::coord_type'($urandom),
               prc_pkg::coord_type'($urandom), prc_pkg::coord_type'($urandom));
      test_random(20);
      set_rect(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
      test_random(30);
      set_rect(16'sd0, 16'sd32767, 16'sd0, 16'sd32767);
      test_random(20);
   endtask

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = prc_pkg::CsrLeft;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.px           = '0;
      req_ch.py           = '0;
      req_ch.red          = '0;
      req_ch.green        = '0;
      req_ch.blue         = '0;
      req_ch.final_vertex = 1'b0;
      rsp_ch.ready        = 1'b0;
      send_idle_pct       = 11;
      recv_idle_pct       = 77;
      error_count         = 0;
      item_count          = 0;
      result_count        = 0;
      cycle_count         = 0;
      bound_left          = prc_pkg::ClipLowReset;
      bound_right         = prc_pkg::ClipHighReset;
      bound_bottom        = prc_pkg::ClipLowReset;
      bound_top           = prc_pkg::ClipHighReset;
      vertex_held         = 1'b0;
      poly_color          = '0;
      for (int s = 0; s < 4; s++) have_first[s] = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(40);
      send_idle_pct = 77;
      recv_idle_pct = 11;
      test_rectangles();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(60);
      wait_idle();

      $display("Sent %0d vertices and checked %0d clipped vertices", item_count,
               result_count);
      $display("over five rectangles, including inverted and full-range ones.");
      if (error_count == 0) begin
         $display("[polygon_rect_clip] OK");
      end else begin
         $display("[polygon_rect_clip] ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/prc_pkg.sv
rtl/core/prc_if.sv
rtl/core/prc_front.sv
rtl/core/prc_div.sv
rtl/core/prc_back.sv
rtl/core/polygon_rect_clip.sv
tb/tb_polygon_rect_clip.sv
